>>> hw/rtl/hsvc_pkg.sv
// ----------------------------------------------------------------------------
// hsvc_pkg
// Shared types and constants for the HSV color pixel classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvc_pkg;

   localparam int CHAN_W      = 8;
   localparam int NUM_W       = 20;   // widest dividend: 3840 * 255
   localparam int QUO_W       = 12;   // hue quotient reaches 3840
   localparam int DIV_STAGES  = QUO_W;
   localparam int HUE_W       = 15;
   localparam int TOL_W       = 14;
   localparam int SAT_CFG_W   = 11;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 15;

   localparam int HUE_SECTOR  = 3840;
   localparam int HUE_TURN    = 23040;
   localparam int HUE_HALF    = 11520;

   localparam logic [HUE_W-1:0]     HUE_CENTER_RST = HUE_W'(8832);
   localparam logic [TOL_W-1:0]     HUE_TOL_RST    = TOL_W'(1408);
   localparam logic [SAT_CFG_W-1:0] SAT_LOW_RST    = SAT_CFG_W'(307);
   localparam logic [SAT_CFG_W-1:0] SAT_HIGH_RST   = SAT_CFG_W'(1034);
   localparam logic [CHAN_W-1:0]    VAL_LOW_RST    = CHAN_W'(10);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HUE_CENTER = 3'd0,
      CSR_HUE_TOL    = 3'd1,
      CSR_SAT_LOW    = 3'd2,
      CSR_SAT_HIGH   = 3'd3,
      CSR_VAL_LOW    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } sector_type;

   typedef struct packed {
      logic [CHAN_W-1:0] mx;
      logic              zero;
      logic              neg;
      sector_type        sector;
   } side_type;

   typedef struct packed {
      logic [HUE_W-1:0]     hue_center;
      logic [TOL_W-1:0]     hue_tolerance;
      logic [SAT_CFG_W-1:0] saturation_low;
      logic [SAT_CFG_W-1:0] saturation_high;
      logic [CHAN_W-1:0]    value_low;
   } cfg_type;

endpackage

`default_nettype wire

>>> hw/rtl/hsvc_ifs.sv
// ----------------------------------------------------------------------------
// hsvc channel interfaces
// Valid/ready channels for pixel requests and match responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsvc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface hsvc_rsp_if;
   logic valid;
   logic ready;
   logic is_match;

   modport source (output valid, output is_match, input ready);
   modport sink   (input valid, input is_match, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hsv_color_pixel_classifier.sv
// Throughput: one item per cycle unless the output stalls; one front stage, twelve
// divider stages (one quotient bit each) and two back stages, all stepping together.
// A stalled output holds the whole pipeline, including req_ch.ready.
// Reset (synchronous) clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// hsv_color_pixel_classifier
// RGB pixel to HSV conversion and color-window match, one item per clock unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_color_pixel_classifier (
   input  wire logic                            clock,
   input  wire logic                            reset,
   hsvc_req_if.sink                             req_ch,
   hsvc_rsp_if.source                           rsp_ch,
   input  wire logic                            csr_wr_en,
   input  wire logic [hsvc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [hsvc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hsvc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   logic              advance;
   logic              f_valid;
   logic [NUM_W-1:0]  f_hue_num, f_sat_num;
   logic [CHAN_W-1:0] f_hue_den, f_sat_den;
   side_type          f_side;

   logic              d_valid;
   logic [QUO_W-1:0]  d_hue_quo, d_sat_quo;
   side_type          d_side;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HUE_CENTER: cfg_in.hue_center      = csr_wdata[HUE_W-1:0];
            CSR_HUE_TOL:    cfg_in.hue_tolerance   = csr_wdata[TOL_W-1:0];
            CSR_SAT_LOW:    cfg_in.saturation_low  = csr_wdata[SAT_CFG_W-1:0];
            CSR_SAT_HIGH:   cfg_in.saturation_high = csr_wdata[SAT_CFG_W-1:0];
            CSR_VAL_LOW:    cfg_in.value_low       = csr_wdata[CHAN_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hue_center      <= HUE_CENTER_RST;
         cfg_ff.hue_tolerance   <= HUE_TOL_RST;
         cfg_ff.saturation_low  <= SAT_LOW_RST;
         cfg_ff.saturation_high <= SAT_HIGH_RST;
         cfg_ff.value_low       <= VAL_LOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ch.ready = advance;

   hsvc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_ch.valid),
      .red       (req_ch.red),
      .green     (req_ch.green),
      .blue      (req_ch.blue),
      .out_valid (f_valid),
      .hue_num   (f_hue_num),
      .hue_den   (f_hue_den),
      .sat_num   (f_sat_num),
      .sat_den   (f_sat_den),
      .side      (f_side)
   );

   hsvc_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (f_valid),
      .hue_num   (f_hue_num),
      .hue_den   (f_hue_den),
      .sat_num   (f_sat_num),
      .sat_den   (f_sat_den),
      .in_side   (f_side),
      .out_valid (d_valid),
      .hue_quo   (d_hue_quo),
      .sat_quo   (d_sat_quo),
      .out_side  (d_side)
   );

   hsvc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .hue_quo   (d_hue_quo),
      .sat_quo   (d_sat_quo),
      .side      (d_side),
      .cfg       (cfg_ff),
      .rsp_ready (rsp_ch.ready),
      .advance   (advance),
      .rsp_valid (rsp_ch.valid),
      .is_match  (rsp_ch.is_match)
   );

endmodule

`default_nettype wire

>>> hw/rtl/hsvc_front.sv
// ----------------------------------------------------------------------------
// hsvc_front
// First stage: max/min, sector pick and the two dividends and divisors.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvc_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic                        in_valid,
   input  wire logic [hsvc_pkg::CHAN_W-1:0] red,
   input  wire logic [hsvc_pkg::CHAN_W-1:0] green,
   input  wire logic [hsvc_pkg::CHAN_W-1:0] blue,
   output logic                             out_valid,
   output logic [hsvc_pkg::NUM_W-1:0]       hue_num,
   output logic [hsvc_pkg::CHAN_W-1:0]      hue_den,
   output logic [hsvc_pkg::NUM_W-1:0]       sat_num,
   output logic [hsvc_pkg::CHAN_W-1:0]      sat_den,
   output hsvc_pkg::side_type               side
);
   import hsvc_pkg::*;

   logic [CHAN_W-1:0] mx, mn, d, a, c, mag;
   logic              neg;
   sector_type        sector;

   logic              valid_ff;
   logic [NUM_W-1:0]  hue_num_ff, hue_num_in, sat_num_ff, sat_num_in;
   logic [CHAN_W-1:0] hue_den_ff, sat_den_ff;
   side_type          side_ff, side_in;

   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      d = mx - mn;

      // first channel equal to the max picks the sector
      if (red == mx) begin
         sector = SECTOR_RED;
         a = green;
         c = blue;
      end else if (green == mx) begin
         sector = SECTOR_GREEN;
         a = blue;
         c = red;
      end else begin
         sector = SECTOR_BLUE;
         a = red;
         c = green;
      end
      neg = a < c;
      mag = neg ? (c - a) : (a - c);

      // 3840 * mag as two shifts
      hue_num_in = (NUM_W'(mag) << 12) - (NUM_W'(mag) << 8);
      sat_num_in = NUM_W'(d) << 10;

      side_in.mx     = mx;
      side_in.zero   = (d == '0);
      side_in.neg    = neg;
      side_in.sector = sector;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hue_num_ff <= hue_num_in;
         hue_den_ff <= d;
         sat_num_ff <= sat_num_in;
         sat_den_ff <= mx;
         side_ff    <= side_in;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid = valid_ff;
   assign hue_num   = hue_num_ff;
   assign hue_den   = hue_den_ff;
   assign sat_num   = sat_num_ff;
   assign sat_den   = sat_den_ff;
   assign side      = side_ff;

endmodule

`default_nettype wire

>>> hw/rtl/hsvc_div_pipe.sv
// ----------------------------------------------------------------------------
// hsvc_div_pipe
// Pipelined restoring dividers for hue and saturation, one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvc_div_pipe (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic                        in_valid,
   input  wire logic [hsvc_pkg::NUM_W-1:0]  hue_num,
   input  wire logic [hsvc_pkg::CHAN_W-1:0] hue_den,
   input  wire logic [hsvc_pkg::NUM_W-1:0]  sat_num,
   input  wire logic [hsvc_pkg::CHAN_W-1:0] sat_den,
   input  wire hsvc_pkg::side_type          in_side,
   output logic                             out_valid,
   output logic [hsvc_pkg::QUO_W-1:0]       hue_quo,
   output logic [hsvc_pkg::QUO_W-1:0]       sat_quo,
   output hsvc_pkg::side_type               out_side
);
   import hsvc_pkg::*;

   // w_* index 0 is the stage input, index i+1 is the output of stage i
   logic              w_valid   [DIV_STAGES+1];
   logic [NUM_W-1:0]  w_hue_rem [DIV_STAGES+1];
   logic [CHAN_W-1:0] w_hue_den [DIV_STAGES+1];
   logic [QUO_W-1:0]  w_hue_q   [DIV_STAGES+1];
   logic [NUM_W-1:0]  w_sat_rem [DIV_STAGES+1];
   logic [CHAN_W-1:0] w_sat_den [DIV_STAGES+1];
   logic [QUO_W-1:0]  w_sat_q   [DIV_STAGES+1];
   side_type          w_side    [DIV_STAGES+1];

   logic              valid_ff   [DIV_STAGES];
   logic [NUM_W-1:0]  hue_rem_ff [DIV_STAGES];
   logic [CHAN_W-1:0] hue_den_ff [DIV_STAGES];
   logic [QUO_W-1:0]  hue_q_ff   [DIV_STAGES];
   logic [NUM_W-1:0]  sat_rem_ff [DIV_STAGES];
   logic [CHAN_W-1:0] sat_den_ff [DIV_STAGES];
   logic [QUO_W-1:0]  sat_q_ff   [DIV_STAGES];
   side_type          side_ff    [DIV_STAGES];

   assign w_valid[0]   = in_valid;
   assign w_hue_rem[0] = hue_num;
   assign w_hue_den[0] = hue_den;
   assign w_hue_q[0]   = '0;
   assign w_sat_rem[0] = sat_num;
   assign w_sat_den[0] = sat_den;
   assign w_sat_q[0]   = '0;
   assign w_side[0]    = in_side;

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      localparam int SHIFT = QUO_W - 1 - i;

      logic [NUM_W-1:0] hue_sh, sat_sh, hue_rem_in, sat_rem_in;
      logic [QUO_W-1:0] hue_q_in, sat_q_in;
      logic             hue_ge, sat_ge;

      always_comb begin
         hue_sh     = NUM_W'(w_hue_den[i]) << SHIFT;
         hue_ge     = w_hue_rem[i] >= hue_sh;
         hue_rem_in = hue_ge ? (w_hue_rem[i] - hue_sh) : w_hue_rem[i];
         hue_q_in   = {w_hue_q[i][QUO_W-2:0], hue_ge};

         sat_sh     = NUM_W'(w_sat_den[i]) << SHIFT;
         sat_ge     = w_sat_rem[i] >= sat_sh;
         sat_rem_in = sat_ge ? (w_sat_rem[i] - sat_sh) : w_sat_rem[i];
         sat_q_in   = {w_sat_q[i][QUO_W-2:0], sat_ge};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            hue_rem_ff[i] <= hue_rem_in;
            hue_den_ff[i] <= w_hue_den[i];
            hue_q_ff[i]   <= hue_q_in;
            sat_rem_ff[i] <= sat_rem_in;
            sat_den_ff[i] <= w_sat_den[i];
            sat_q_ff[i]   <= sat_q_in;
            side_ff[i]    <= w_side[i];
         end
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= w_valid[i];
         end
      end

      assign w_valid[i+1]   = valid_ff[i];
      assign w_hue_rem[i+1] = hue_rem_ff[i];
      assign w_hue_den[i+1] = hue_den_ff[i];
      assign w_hue_q[i+1]   = hue_q_ff[i];
      assign w_sat_rem[i+1] = sat_rem_ff[i];
      assign w_sat_den[i+1] = sat_den_ff[i];
      assign w_sat_q[i+1]   = sat_q_ff[i];
      assign w_side[i+1]    = side_ff[i];
   end

   assign out_valid = w_valid[DIV_STAGES];
   assign hue_quo   = w_hue_q[DIV_STAGES];
   assign sat_quo   = w_sat_q[DIV_STAGES];
   assign out_side  = w_side[DIV_STAGES];

   // final remainders and divisors are not needed downstream
   logic unused_rem;
   assign unused_rem = ^{w_hue_rem[DIV_STAGES], w_sat_rem[DIV_STAGES],
                         w_hue_den[DIV_STAGES], w_sat_den[DIV_STAGES]};

endmodule

`default_nettype wire

>>> hw/rtl/hsvc_back.sv
// ----------------------------------------------------------------------------
// hsvc_back
// Hue assembly, threshold tests, circular hue distance and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvc_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic [hsvc_pkg::QUO_W-1:0] hue_quo,
   input  wire logic [hsvc_pkg::QUO_W-1:0] sat_quo,
   input  wire hsvc_pkg::side_type         side,
   input  wire hsvc_pkg::cfg_type          cfg,
   input  wire logic                       rsp_ready,
   output logic                            advance,
   output logic                            rsp_valid,
   output logic                            is_match
);
   import hsvc_pkg::*;

   logic signed [15:0] base, mag, hue_s;
   logic [HUE_W-1:0]   hue_in, hue_ff;
   logic [QUO_W-1:0]   sat;
   logic               sat_ok_in, val_ok_in, sat_ok_ff, val_ok_ff, s1_valid_ff;

   logic signed [16:0] diff, hue_gap;
   logic               match_in, match_ff, out_valid_ff;

   // whole pipeline moves together; holds while the output item waits
   assign advance = !out_valid_ff || rsp_ready;

   always_comb begin
      unique case (side.sector)
         SECTOR_RED:   base = '0;
         SECTOR_GREEN: base = signed'(16'(2 * HUE_SECTOR));
         SECTOR_BLUE:  base = signed'(16'(4 * HUE_SECTOR));
         default:      base = '0;
      endcase
      mag   = signed'(16'(hue_quo));
      hue_s = side.neg ? (base - mag) : (base + mag);
      if (hue_s < 0) begin
         hue_s = hue_s + signed'(16'(HUE_TURN));
      end
      hue_in = side.zero ? '0 : hue_s[HUE_W-1:0];

      sat       = side.zero ? '0 : sat_quo;
      sat_ok_in = (sat > QUO_W'(cfg.saturation_low)) && (sat < QUO_W'(cfg.saturation_high));
      val_ok_in = side.mx > cfg.value_low;
   end

   always_comb begin
      diff    = signed'(17'(hue_ff)) - signed'(17'(cfg.hue_center));
      hue_gap = (diff < 0) ? -diff : diff;
      // out-of-range target can leave the folded distance negative
      if (hue_gap > signed'(17'(HUE_HALF))) begin
         hue_gap = signed'(17'(HUE_TURN)) - hue_gap;
      end
      match_in = (hue_gap < signed'(17'(cfg.hue_tolerance))) && sat_ok_ff && val_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hue_ff    <= hue_in;
         sat_ok_ff <= sat_ok_in;
         val_ok_ff <= val_ok_in;
         match_ff  <= match_in;
      end
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= in_valid;
         out_valid_ff <= s1_valid_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign is_match  = match_ff;

endmodule

`default_nettype wire

>>> hw/rtl/hsvc_checker.sv
// ----------------------------------------------------------------------------
// hsvc_checker
// Port-level checks on the classifier's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic is_match
);

   // stalled result item stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(is_match)))
      else $error("rsp item changed while stalled");

   // empty output slot never pushes back on the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req not ready with empty output");

   // a waiting result stalls the whole pipeline
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("req accepted while output stalled");

   // reset flushes everything in flight
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   logic unused_req_valid;
   assign unused_req_valid = req_valid;

endmodule

bind hsv_color_pixel_classifier hsvc_checker u_hsvc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .is_match  (rsp_ch.is_match)
);

`default_nettype wire
